// File: design/psvt_pkg.sv
// ----------------------------------------------------------------------------
// psvt_pkg
// types and constants shared by the pair set vote table
// ----------------------------------------------------------------------------
`default_nettype none

package psvt_pkg;

  localparam int MATRIX_WORDS = 9;
  localparam int ID_W         = 10;
  localparam int PAIR_W       = 2 * ID_W;
  localparam int SIZE_W       = 5;
  localparam int VOTE_W       = 16;
  localparam int STARS_W      = 10;
  localparam int SUMSQ_W      = 32;
  localparam int WORD_W       = 32;
  localparam int WIDX_W       = 4;

  localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(MATRIX_WORDS - 1);
  localparam logic [VOTE_W-1:0] VOTE_MAX  = '1;

  typedef enum logic [1:0] {
    OP_STAGE  = 2'd0,
    OP_ADD    = 2'd1,
    OP_SELECT = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_VOTE   = 2'd0,
    ST_NEW    = 2'd1,
    ST_DROP   = 2'd2,
    ST_SELECT = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_MRD,
    S_SRCH_MCHK,
    S_SRCH_PRD,
    S_SRCH_PCHK,
    S_NEXT,
    S_MISS,
    S_APP_PAIR,
    S_APP_MAT,
    S_EMIT,
    S_SEL_MRD,
    S_SEL_MCHK,
    S_SEL_WRD,
    S_SEL_OUT
  } state_t;

  typedef struct packed {
    op_t                       op;
    logic [ID_W-1:0]           id_ref;
    logic [ID_W-1:0]           id_in;
    logic                      pair_last;
    logic [SIZE_W-1:0]         set_size;
    logic [STARS_W-1:0]        star_count;
    logic [SUMSQ_W-1:0]        sum_squares;
    logic [WIDX_W-1:0]         matrix_index;
    logic signed [WORD_W-1:0]  matrix_word;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                status;
    logic [VOTE_W-1:0]         vote_count;
    logic                      found;
    logic [STARS_W-1:0]        best_stars;
    logic [SUMSQ_W-1:0]        best_sum_squares;
    logic [WIDX_W-1:0]         word_index;
    logic signed [WORD_W-1:0]  word_value;
    logic                      last;
  } out_item_t;

  typedef struct packed {
    logic [SIZE_W-1:0]  size;
    logic [VOTE_W-1:0]  votes;
    logic [STARS_W-1:0] stars;
    logic [SUMSQ_W-1:0] sumsq;
  } meta_t;

  typedef struct packed {
    logic              pair_we;
    logic              mat_we;
    logic [WIDX_W-1:0] mat_idx;
  } stage_ctl_t;

endpackage

`default_nettype wire

// File: design/psvt_ram.sv
// ----------------------------------------------------------------------------
// psvt_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module psvt_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: design/psvt_stage.sv
// ----------------------------------------------------------------------------
// psvt_stage
// staged pairs and matrix words of the open request, with pair membership probe
// ----------------------------------------------------------------------------
`default_nettype none

module psvt_stage import psvt_pkg::*; #(
  parameter int MAX_PAIRS = 19,
  localparam int SIW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1,
  localparam int PCW = $clog2(MAX_PAIRS + 2)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire stage_ctl_t               ctl,
  input  wire logic [SIW-1:0]           wr_idx,
  input  wire logic [PAIR_W-1:0]        wr_pair,
  input  wire logic signed [WORD_W-1:0] wr_word,
  input  wire logic [PCW-1:0]           probe_n,
  input  wire logic [PAIR_W-1:0]        probe_pair,
  output logic                          probe_seen,
  input  wire logic [SIW-1:0]           rd_idx,
  output logic [PAIR_W-1:0]             rd_pair,
  input  wire logic [WIDX_W-1:0]        mat_rd_idx,
  output logic signed [WORD_W-1:0]      rd_word
);

  logic [PAIR_W-1:0]        pairs_r [MAX_PAIRS];
  logic signed [WORD_W-1:0] mat_r [MATRIX_WORDS];

  always_ff @(posedge clk) begin
    if (ctl.pair_we) begin
      pairs_r[wr_idx] <= wr_pair;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MATRIX_WORDS; i++) begin
        mat_r[i] <= '0;
      end
    end else if (ctl.mat_we && (ctl.mat_idx < WIDX_W'(MATRIX_WORDS))) begin
      mat_r[ctl.mat_idx] <= wr_word;
    end
  end

  always_comb begin
    probe_seen = 1'b0;
    for (int k = 0; k < MAX_PAIRS; k++) begin
      if ((PCW'(k) < probe_n) && (pairs_r[k] == probe_pair)) begin
        probe_seen = 1'b1;
      end
    end
  end

  assign rd_pair = pairs_r[rd_idx];
  assign rd_word = mat_r[mat_rd_idx];

endmodule

`default_nettype wire

// File: design/pair_set_vote_table_core.sv
// ----------------------------------------------------------------------------
// pair_set_vote_table_core
// vote table of candidate star match transformations
// ----------------------------------------------------------------------------
// Requests are taken one at a time. Stage, clear and non-final add requests
// are handled in the idle state itself. A final add of a valid size walks the
// entry memory entry by entry, reading pairs from the pair memory for entries
// of equal size; a miss then writes n pairs and nine matrix words, one per
// cycle, unless the table is full. A select reads the entry memory entry by
// entry, then returns nine results, each waiting for a free output. The single
// read port of each memory sets the pace. No clearing pass is needed after reset.
`default_nettype none

module pair_set_vote_table_core import psvt_pkg::*; #(
  parameter int MAX_ENTRIES = 64,
  parameter int MAX_PAIRS   = 19
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam int EW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW     = $clog2(MAX_ENTRIES + 1);
  localparam int PCW    = $clog2(MAX_PAIRS + 2);
  localparam int SIW    = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int PDEPTH = MAX_ENTRIES * MAX_PAIRS;
  localparam int PAW    = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
  localparam int MDEPTH = MAX_ENTRIES * MATRIX_WORDS;
  localparam int MAW    = $clog2(MDEPTH);

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     e_r, e_nxt;
  logic [PCW-1:0]    j_r, j_nxt;
  logic [WIDX_W-1:0] k_r, k_nxt;
  logic [PCW-1:0]    n_r, n_nxt;
  logic [PCW-1:0]    spc_r, spc_nxt;
  logic [PAW-1:0]    pbase_r, pbase_nxt;
  logic [MAW-1:0]    mbase_r, mbase_nxt;
  logic [PAW-1:0]    tail_pbase_r, tail_pbase_nxt;
  logic [MAW-1:0]    tail_mbase_r, tail_mbase_nxt;
  logic [MAW-1:0]    best_mbase_r, best_mbase_nxt;
  meta_t             best_r, best_nxt;
  logic              found_r, found_nxt;
  in_item_t          in_r, in_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [VOTE_W-1:0] res_votes_r, res_votes_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_nxt;

  logic              in_fire, out_free, out_load;
  logic [PCW-1:0]    spc_inc;
  logic              seen;
  logic [PAIR_W-1:0] stage_pair;
  logic signed [WORD_W-1:0] stage_word;
  stage_ctl_t        stage_ctl;
  meta_t             meta_rd, meta_wd;
  logic [$bits(meta_t)-1:0] meta_rdata;
  logic              meta_we, meta_re;
  logic [EW-1:0]     meta_waddr;
  logic              pair_we, pair_re;
  logic [PAIR_W-1:0] pair_rdata;
  logic              mat_we, mat_re;
  logic [WORD_W-1:0] mat_rdata;
  logic              last_pair, full, better;

  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign meta_rd   = meta_t'(meta_rdata);
  assign spc_inc   = (spc_r < PCW'(MAX_PAIRS)) ? PCW'(spc_r + 1'b1) : PCW'(MAX_PAIRS + 1);
  assign last_pair = (PCW'(j_r + 1'b1) == n_r);
  assign full      = (cnt_r == CW'(MAX_ENTRIES));
  assign better    = (meta_rd.size > best_r.size) ||
                     ((meta_rd.size == best_r.size) && (meta_rd.votes > best_r.votes));

  psvt_stage #(.MAX_PAIRS(MAX_PAIRS)) u_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (stage_ctl),
    .wr_idx     (spc_r[SIW-1:0]),
    .wr_pair    ({in_data.id_ref, in_data.id_in}),
    .wr_word    (in_data.matrix_word),
    .probe_n    (n_r),
    .probe_pair (pair_rdata),
    .probe_seen (seen),
    .rd_idx     (j_r[SIW-1:0]),
    .rd_pair    (stage_pair),
    .mat_rd_idx (k_r),
    .rd_word    (stage_word)
  );

  psvt_ram #(.W($bits(meta_t)), .D(MAX_ENTRIES)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wd),
    .re    (meta_re),
    .raddr (e_r[EW-1:0]),
    .rdata (meta_rdata)
  );

  psvt_ram #(.W(PAIR_W), .D(PDEPTH)) u_pair_ram (
    .clk   (clk),
    .we    (pair_we),
    .waddr (PAW'(tail_pbase_r + PAW'(j_r))),
    .wdata (stage_pair),
    .re    (pair_re),
    .raddr (PAW'(pbase_r + PAW'(j_r))),
    .rdata (pair_rdata)
  );

  psvt_ram #(.W(WORD_W), .D(MDEPTH)) u_mat_ram (
    .clk   (clk),
    .we    (mat_we),
    .waddr (MAW'(tail_mbase_r + MAW'(k_r))),
    .wdata (stage_word),
    .re    (mat_re),
    .raddr (MAW'(best_mbase_r + MAW'(k_r))),
    .rdata (mat_rdata)
  );

  // next state
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    e_nxt          = e_r;
    j_nxt          = j_r;
    k_nxt          = k_r;
    n_nxt          = n_r;
    spc_nxt        = spc_r;
    pbase_nxt      = pbase_r;
    mbase_nxt      = mbase_r;
    tail_pbase_nxt = tail_pbase_r;
    tail_mbase_nxt = tail_mbase_r;
    best_mbase_nxt = best_mbase_r;
    best_nxt       = best_r;
    found_nxt      = found_r;
    in_nxt         = in_r;
    res_status_nxt = res_status_r;
    res_votes_nxt  = res_votes_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_data.op)
            OP_STAGE: begin
            end
            OP_ADD: begin
              spc_nxt = spc_inc;
              if (in_data.pair_last) begin
                spc_nxt   = '0;
                n_nxt     = spc_inc;
                in_nxt    = in_data;
                e_nxt     = '0;
                j_nxt     = '0;
                pbase_nxt = '0;
                if ((spc_inc > PCW'(MAX_PAIRS)) ||
                    (32'(in_data.set_size) != 32'(spc_inc))) begin
                  res_status_nxt = ST_DROP;
                  res_votes_nxt  = '0;
                  state_nxt      = S_EMIT;
                end else if (cnt_r == '0) begin
                  state_nxt = S_MISS;
                end else begin
                  state_nxt = S_SRCH_MRD;
                end
              end
            end
            OP_SELECT: begin
              e_nxt          = '0;
              k_nxt          = '0;
              mbase_nxt      = '0;
              best_mbase_nxt = '0;
              best_nxt       = '0;
              found_nxt      = 1'b0;
              state_nxt      = (cnt_r == '0) ? S_SEL_WRD : S_SEL_MRD;
            end
            OP_CLEAR: begin
              cnt_nxt        = '0;
              tail_pbase_nxt = '0;
              tail_mbase_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SRCH_MRD: begin
        state_nxt = S_SRCH_MCHK;
      end
      S_SRCH_MCHK: begin
        j_nxt     = '0;
        state_nxt = (32'(meta_rd.size) == 32'(n_r)) ? S_SRCH_PRD : S_NEXT;
      end
      S_SRCH_PRD: begin
        state_nxt = S_SRCH_PCHK;
      end
      S_SRCH_PCHK: begin
        if (!seen) begin
          state_nxt = S_NEXT;
        end else if (last_pair) begin
          res_status_nxt = ST_VOTE;
          res_votes_nxt  = meta_wd.votes;
          state_nxt      = S_EMIT;
        end else begin
          j_nxt     = PCW'(j_r + 1'b1);
          state_nxt = S_SRCH_PRD;
        end
      end
      S_NEXT: begin
        e_nxt     = CW'(e_r + 1'b1);
        pbase_nxt = PAW'(pbase_r + PAW'(MAX_PAIRS));
        state_nxt = (CW'(e_r + 1'b1) == cnt_r) ? S_MISS : S_SRCH_MRD;
      end
      S_MISS: begin
        j_nxt = '0;
        k_nxt = '0;
        if (full) begin
          res_status_nxt = ST_DROP;
          res_votes_nxt  = '0;
          state_nxt      = S_EMIT;
        end else begin
          state_nxt = S_APP_PAIR;
        end
      end
      S_APP_PAIR: begin
        j_nxt = PCW'(j_r + 1'b1);
        if (last_pair) begin
          state_nxt = S_APP_MAT;
        end
      end
      S_APP_MAT: begin
        k_nxt = WIDX_W'(k_r + 1'b1);
        if (k_r == LAST_WORD) begin
          cnt_nxt        = CW'(cnt_r + 1'b1);
          tail_pbase_nxt = PAW'(tail_pbase_r + PAW'(MAX_PAIRS));
          tail_mbase_nxt = MAW'(tail_mbase_r + MAW'(MATRIX_WORDS));
          res_status_nxt = ST_NEW;
          res_votes_nxt  = VOTE_W'(1);
          state_nxt      = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_SEL_MRD: begin
        state_nxt = S_SEL_MCHK;
      end
      S_SEL_MCHK: begin
        if (better) begin
          best_nxt       = meta_rd;
          best_mbase_nxt = mbase_r;
          found_nxt      = 1'b1;
        end
        if (CW'(e_r + 1'b1) == cnt_r) begin
          state_nxt = S_SEL_WRD;
        end else begin
          e_nxt     = CW'(e_r + 1'b1);
          mbase_nxt = MAW'(mbase_r + MAW'(MATRIX_WORDS));
          state_nxt = S_SEL_MRD;
        end
      end
      S_SEL_WRD: begin
        state_nxt = S_SEL_OUT;
      end
      S_SEL_OUT: begin
        if (out_free) begin
          if (k_r == LAST_WORD) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = WIDX_W'(k_r + 1'b1);
            state_nxt = S_SEL_WRD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // outputs and memory control
  always_comb begin
    in_ready          = (state_r == S_IDLE);
    stage_ctl.pair_we = in_fire && (in_data.op == OP_ADD) && (spc_r < PCW'(MAX_PAIRS));
    stage_ctl.mat_we  = in_fire && (in_data.op == OP_STAGE);
    stage_ctl.mat_idx = in_data.matrix_index;
    meta_re    = (state_r == S_SRCH_MRD) || (state_r == S_SEL_MRD);
    pair_re    = (state_r == S_SRCH_PRD);
    pair_we    = (state_r == S_APP_PAIR);
    mat_re     = (state_r == S_SEL_WRD);
    mat_we     = (state_r == S_APP_MAT);
    meta_we    = 1'b0;
    meta_waddr = e_r[EW-1:0];
    meta_wd    = meta_rd;
    if (meta_rd.votes != VOTE_MAX) begin
      meta_wd.votes = VOTE_W'(meta_rd.votes + 1'b1);
    end
    if (state_r == S_SRCH_PCHK) begin
      meta_we = seen && last_pair;
    end else if (state_r == S_MISS) begin
      meta_we       = !full;
      meta_waddr    = cnt_r[EW-1:0];
      meta_wd.size  = SIZE_W'(n_r);
      meta_wd.votes = VOTE_W'(1);
      meta_wd.stars = in_r.star_count;
      meta_wd.sumsq = in_r.sum_squares;
    end
    out_load = 1'b0;
    out_nxt  = '0;
    if (state_r == S_EMIT) begin
      out_load           = out_free;
      out_nxt.status     = res_status_r;
      out_nxt.vote_count = res_votes_r;
      out_nxt.last       = 1'b1;
    end else if (state_r == S_SEL_OUT) begin
      out_load                 = out_free;
      out_nxt.status           = ST_SELECT;
      out_nxt.vote_count       = best_r.votes;
      out_nxt.found            = found_r;
      out_nxt.best_stars       = best_r.stars;
      out_nxt.best_sum_squares = best_r.sumsq;
      out_nxt.word_index       = k_r;
      out_nxt.word_value       = found_r ? mat_rdata : '0;
      out_nxt.last             = (k_r == LAST_WORD);
    end
    out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      spc_r       <= '0;
      out_valid_r <= 1'b0;
      tail_pbase_r <= '0;
      tail_mbase_r <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      spc_r       <= spc_nxt;
      out_valid_r <= out_valid_nxt;
      tail_pbase_r <= tail_pbase_nxt;
      tail_mbase_r <= tail_mbase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r          <= e_nxt;
    j_r          <= j_nxt;
    k_r          <= k_nxt;
    n_r          <= n_nxt;
    pbase_r      <= pbase_nxt;
    mbase_r      <= mbase_nxt;
    best_mbase_r <= best_mbase_nxt;
    best_r       <= best_nxt;
    found_r      <= found_nxt;
    in_r         <= in_nxt;
    res_status_r <= res_status_nxt;
    res_votes_r  <= res_votes_nxt;
    if (out_load) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_ENTRIES))
    else $error("entry count beyond table depth");

  a_spc_range: assert property (@(posedge clk) disable iff (!rst_n)
    spc_r <= PCW'(MAX_PAIRS + 1))
    else $error("staged pair count beyond limit");

  a_append_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APP_MAT) && (k_r == LAST_WORD) |=> cnt_r == CW'($past(cnt_r) + 1'b1))
    else $error("append did not advance entry count");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_data.op == OP_CLEAR) |=> cnt_r == '0)
    else $error("clear left entries in table");

endmodule

`default_nettype wire

// File: dv/psvt_checker.sv
// ----------------------------------------------------------------------------
// psvt_checker
// watches both channels of the vote table, predicts its results and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module psvt_checker import psvt_pkg::*; #(
  parameter int MAX_ENTRIES = 64,
  parameter int MAX_PAIRS   = 19
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_ready,
  input  wire in_item_t  in_data,
  input  wire logic      out_valid,
  input  wire logic      out_ready,
  input  wire out_item_t out_data,
  output int             fail_count,
  output int             pending,
  output int             result_count
);

  logic [PAIR_W-1:0]  tbl_pairs [MAX_ENTRIES][MAX_PAIRS];
  logic [SIZE_W-1:0]  tbl_size  [MAX_ENTRIES];
  logic [VOTE_W-1:0]  tbl_votes [MAX_ENTRIES];
  logic [STARS_W-1:0] tbl_stars [MAX_ENTRIES];
  logic [SUMSQ_W-1:0] tbl_sumsq [MAX_ENTRIES];
  logic [WORD_W-1:0]  tbl_mat   [MAX_ENTRIES][MATRIX_WORDS];
  int                 tbl_used;
  logic [PAIR_W-1:0]  set_pairs [MAX_PAIRS];
  int                 set_len;
  logic [WORD_W-1:0]  held_mat  [MATRIX_WORDS];
  out_item_t          expected_results [$];

  function automatic out_item_t add_result(status_t st, logic [VOTE_W-1:0] v);
    out_item_t r;
    r = '0;
    r.status = st;
    r.vote_count = v;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic bit set_matches(int e);
    bit seen;
    if (tbl_size[e] != set_len) return 0;
    for (int j = 0; j < set_len; j++) begin
      seen = 0;
      for (int k = 0; k < set_len; k++)
        if (set_pairs[k] == tbl_pairs[e][j]) seen = 1;
      if (!seen) return 0;
    end
    return 1;
  endfunction

  task automatic close_set(in_item_t it);
    int n;
    n = set_len;
    if (n > MAX_PAIRS || it.set_size != n) begin
      set_len = 0;
      expected_results.push_back(add_result(ST_DROP, '0));
      return;
    end
    for (int e = 0; e < tbl_used; e++) begin
      if (set_matches(e)) begin
        if (tbl_votes[e] != VOTE_MAX) tbl_votes[e]++;
        set_len = 0;
        expected_results.push_back(add_result(ST_VOTE, tbl_votes[e]));
        return;
      end
    end
    set_len = 0;
    if (tbl_used >= MAX_ENTRIES) begin
      expected_results.push_back(add_result(ST_DROP, '0));
      return;
    end
    tbl_size[tbl_used] = SIZE_W'(n);
    tbl_votes[tbl_used] = VOTE_W'(1);
    tbl_stars[tbl_used] = it.star_count;
    tbl_sumsq[tbl_used] = it.sum_squares;
    for (int j = 0; j < n; j++) tbl_pairs[tbl_used][j] = set_pairs[j];
    for (int j = 0; j < MATRIX_WORDS; j++) tbl_mat[tbl_used][j] = held_mat[j];
    tbl_used++;
    expected_results.push_back(add_result(ST_NEW, VOTE_W'(1)));
  endtask

  task automatic predict_select();
    int best;
    int bn;
    int bv;
    bit hit;
    out_item_t r;
    best = 0; bn = 0; bv = 0; hit = 0;
    for (int e = 0; e < tbl_used; e++) begin
      if (tbl_size[e] > bn || (tbl_size[e] == bn && tbl_votes[e] > bv)) begin
        bn = tbl_size[e];
        bv = tbl_votes[e];
        best = e;
        hit = 1;
      end
    end
    for (int k = 0; k < MATRIX_WORDS; k++) begin
      r = '0;
      r.status = ST_SELECT;
      r.word_index = WIDX_W'(k);
      r.last = (k == MATRIX_WORDS - 1);
      if (hit) begin
        r.vote_count = tbl_votes[best];
        r.found = 1'b1;
        r.best_stars = tbl_stars[best];
        r.best_sum_squares = tbl_sumsq[best];
        r.word_value = tbl_mat[best][k];
      end
      expected_results.push_back(r);
    end
  endtask

  task automatic predict(in_item_t it);
    case (it.op)
      OP_STAGE: begin
        if (it.matrix_index < MATRIX_WORDS) held_mat[it.matrix_index] = it.matrix_word;
      end
      OP_ADD: begin
        if (set_len < MAX_PAIRS) begin
          set_pairs[set_len] = {it.id_ref, it.id_in};
          set_len++;
        end else begin
          set_len = MAX_PAIRS + 1;
        end
        if (it.pair_last) close_set(it);
      end
      OP_SELECT: predict_select();
      default: tbl_used = 0;
    endcase
  endtask

  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst_n) begin
      tbl_used = 0;
      set_len = 0;
      for (int j = 0; j < MATRIX_WORDS; j++) held_mat[j] = '0;
      expected_results.delete();
      fail_count = 0;
      result_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        result_count++;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %p", out_data);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_data !== exp_r) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: expected %p actual %p", exp_r, out_data);
          end
        end
      end
      if (in_valid && in_ready) predict(in_data);
    end
    pending = expected_results.size();
  end

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stimulus for the pair set vote table: directed sets and selects, then
// random sets, some malformed, under several idling phases and back pressure
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
  import psvt_pkg::*;

  localparam int LIMIT = 10000000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  int        fail_count;
  int        pending;
  int        result_count;
  int        cycles;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        hold_cycles;
  int        requests_sent;
  logic [PAIR_W-1:0] pool [4][19];
  int        pool_len [4];

  pair_set_vote_table_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  psvt_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending(pending), .result_count(result_count)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  initial begin
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send(in_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
  endtask

  function automatic in_item_t rand_item();
    in_item_t it;
    it = in_item_t'($bits(in_item_t)'({$urandom, $urandom, $urandom, $urandom}));
    return it;
  endfunction

  task automatic stage(int idx, logic [WORD_W-1:0] w);
    in_item_t it;
    it = rand_item();
    it.op = OP_STAGE;
    it.matrix_index = WIDX_W'(idx);
    it.matrix_word = w;
    send(it);
  endtask

  task automatic add_pair(logic [PAIR_W-1:0] p, bit fin, int sz);
    in_item_t it;
    it = rand_item();
    it.op = OP_ADD;
    {it.id_ref, it.id_in} = p;
    it.pair_last = fin;
    it.set_size = SIZE_W'(sz);
    send(it);
  endtask

  task automatic op_only(op_t o);
    in_item_t it;
    it = rand_item();
    it.op = o;
    send(it);
  endtask

  // one set from pool slot s, optionally shuffled or with a random size
  task automatic add_set(int s, bit shuffle, bit bad_size);
    int n;
    int a;
    int b;
    logic [PAIR_W-1:0] p [19];
    logic [PAIR_W-1:0] t;
    n = pool_len[s];
    for (int j = 0; j < n; j++) p[j] = pool[s][j];
    if (shuffle)
      for (int j = 0; j < n; j++) begin
        a = $urandom_range(n - 1); b = $urandom_range(n - 1);
        t = p[a]; p[a] = p[b]; p[b] = t;
      end
    for (int j = 0; j < n; j++)
      add_pair(p[j], j == n - 1, bad_size ? $urandom_range(31) : n);
  endtask

  task automatic fill_pool(int s, int n);
    pool_len[s] = n;
    for (int j = 0; j < n; j++) pool[s][j] = PAIR_W'($urandom);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    int r;
    int s;
    int stop;
    stop = requests_sent + count;
    while (requests_sent < stop) begin
      r = $urandom_range(99);
      s = $urandom_range(3);
      if (r < 10) begin
        stage($urandom_range(15), $urandom);
      end else if (r < 55) begin
        if ($urandom_range(3) == 0) fill_pool(s, $urandom_range(3, 6));
        add_set(s, 1, 0);
      end else if (r < 62) begin
        add_set(s, 0, 1);
      end else if (r < 67) begin
        add_pair(PAIR_W'($urandom), $urandom_range(1), $urandom_range(31));
      end else if (r < 90) begin
        op_only(OP_SELECT);
      end else if (r < 93) begin
        op_only(OP_CLEAR);
      end else begin
        fill_pool(s, 19);
        add_set(s, 1, 0);
      end
    end
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    requests_sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty select, extremes, overflow, duplicates, full table
    op_only(OP_SELECT);
    stage(0, 32'h8000_0000);
    stage(8, 32'h7fff_ffff);
    stage(9, 32'h1234_5678);
    stage(15, 32'hffff_ffff);
    pool_len[0] = 3;
    pool[0][0] = '0; pool[0][1] = '1; pool[0][2] = 20'h5a5a5;
    add_set(0, 0, 0);
    add_set(0, 1, 0);
    add_pair('1, 0, 0);
    add_pair('1, 0, 0);
    add_pair('0, 1, 3);
    fill_pool(1, 19);
    add_set(1, 0, 0);
    for (int j = 0; j < 20; j++) add_pair(PAIR_W'(j), j == 19, 19);
    for (int j = 0; j < 20; j++) add_pair(PAIR_W'(j), j == 19, 20);
    add_pair(PAIR_W'(7), 0, 0);
    op_only(OP_CLEAR);
    add_pair(PAIR_W'(8), 0, 0);
    add_pair(PAIR_W'(9), 1, 3);
    op_only(OP_SELECT);
    wait_drained();
    op_only(OP_CLEAR);
    for (int e = 0; e < 66; e++) begin
      add_pair(PAIR_W'(e), 0, 3);
      add_pair(PAIR_W'(e + 1000), 0, 3);
      add_pair(PAIR_W'(e + 2000), 1, 3);
    end
    op_only(OP_SELECT);
    op_only(OP_CLEAR);
    fill_pool(0, 4); fill_pool(1, 5); fill_pool(2, 3); fill_pool(3, 6);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 50 : (ph == 3) ? 19 : 0;
      recv_stall_pct = (ph == 2) ? 50 : (ph == 3) ? 19 : 0;
      if (ph == 2) hold_cycles = 2000;
      random_phase(55);
      wait_drained();
    end

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("%0d requests sent, %0d results checked over four idling phases",
             requests_sent, result_count);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
